[design/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside of reset.
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Expression must never be true at a rising clock edge outside of reset.
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`endif

[design/mtfc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mtfc_pkg;

   // Width of one symbol and of one list entry.
   localparam int SYM_W = 8;

   // Direction register codes.
   typedef enum logic {
      DIR_ENCODE = 1'b0,
      DIR_DECODE = 1'b1
   } dir_type;

   // Controls broadcast from the top level to every cell of the list.
   typedef struct packed {
      logic             update;
      logic             reload;
   } cell_ctl_type;

endpackage

`default_nettype wire

[design/mtfc_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

// One entry of the recency list. On an update the cell keeps its value,
// takes the value its front neighbor held, which shifts the list back by
// one up to the moved entry, or on a reload returns to its home index.
module mtfc_cell #(
   parameter int INDEX = 0
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire mtfc_pkg::cell_ctl_type      ctl,
   input  wire logic                        shift,
   input  wire logic [mtfc_pkg::SYM_W-1:0]  prev_value,
   input  wire logic [mtfc_pkg::SYM_W-1:0]  probe,
   output logic                             match,
   output logic [mtfc_pkg::SYM_W-1:0]       value
);
   import mtfc_pkg::*;

   localparam logic [SYM_W-1:0] HOME = SYM_W'(INDEX);

   logic [SYM_W-1:0] value_ff;
   logic [SYM_W-1:0] value_in;

   // Next entry value: identity on reload, neighbor value on a shift.
   always_comb begin
      value_in = value_ff;
      if (ctl.update) begin
         if (ctl.reload) begin
            value_in = HOME;
         end else if (shift) begin
            value_in = prev_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= HOME;
      end else begin
         value_ff <= value_in;
      end
   end

   // Compare against the incoming byte for encode lookups.
   assign match = (value_ff == probe);
   assign value = value_ff;

endmodule

`default_nettype wire

[design/move_to_front_coder_unit.sv]
// An accepted req word has its lookup registered in the hit vector, and its
// rsp word is registered when the list update runs. The lookup and the update
// both use the cell row, so no new req word is taken before the last update.
// A waiting rsp word holds the update of the following word until it is taken.
// Reset (synchronous, active high) restores the identity order, sets the
// direction to encode and empties the pipeline.
`timescale 1ns / 1ps
`default_nettype none

module move_to_front_coder_unit #(
   parameter int SYMBOL_COUNT = 256
) (
   input  wire logic       clock,
   input  wire logic       reset,
   // Configuration: bit 0 is direction.
   input  wire logic       csr_write_enable,
   input  wire logic       csr_write_data,
   // Input words.
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] symbol_in
   input  wire logic       req_tlast,   // block_end
   // Result words.
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata    // [7:0] symbol_out
);
   import mtfc_pkg::*;

   localparam int IDX_W = $clog2(SYMBOL_COUNT);
   localparam logic [SYM_W:0] COUNT_EXT = (SYM_W+1)'(SYMBOL_COUNT);
   localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(SYMBOL_COUNT - 1);

   dir_type direction_ff;

   logic                    busy_ff;
   logic                    busy_in;
   logic                    last_ff;
   logic [SYMBOL_COUNT-1:0] hit_ff;
   logic [SYMBOL_COUNT-1:0] hit_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic [SYM_W-1:0]        rsp_data_ff;
   logic [SYM_W-1:0]        rsp_data_in;

   logic                    accept;
   logic                    upd_go;
   logic [IDX_W-1:0]        dec_pos;
   logic [SYM_W-1:0]        idx_or;
   logic [SYM_W-1:0]        val_or;
   cell_ctl_type            cell_ctl;
   logic [SYMBOL_COUNT-1:0] cell_match;
   logic [SYMBOL_COUNT-1:0] cell_shift;
   logic [SYM_W-1:0]        cell_value [SYMBOL_COUNT];
   logic [SYM_W-1:0]        cell_prev  [SYMBOL_COUNT];

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= DIR_ENCODE;
      end else if (csr_write_enable) begin
         direction_ff <= dir_type'(csr_write_data);
      end
   end

   // Handshake: take a word when no lookup is pending; the update waits
   // for room in the output register.
   assign req_tready = !busy_ff;
   assign accept     = req_tvalid && req_tready;
   assign upd_go     = busy_ff && (!rsp_valid_ff || rsp_tready);

   // Lookup: one-hot vector of the list position that moves to the front.
   always_comb begin
      if ({1'b0, req_tdata} >= COUNT_EXT) begin
         dec_pos = LAST_POS;
      end else begin
         dec_pos = req_tdata[IDX_W-1:0];
      end
      for (int i = 0; i < SYMBOL_COUNT; i++) begin
         if (direction_ff == DIR_DECODE) begin
            hit_in[i] = (dec_pos == IDX_W'(i));
         end else begin
            hit_in[i] = cell_match[i];
         end
      end
   end

   // Position and value of the selected entry; none selected gives zero.
   always_comb begin
      idx_or = '0;
      val_or = '0;
      for (int i = 0; i < SYMBOL_COUNT; i++) begin
         if (hit_ff[i]) begin
            idx_or = idx_or | SYM_W'(i);
            val_or = val_or | cell_value[i];
         end
      end
      rsp_data_in = (direction_ff == DIR_DECODE) ? val_or : idx_or;
   end

   // Pipeline control and output register.
   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (upd_go) begin
         busy_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (upd_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hit_ff  <= hit_in;
         last_ff <= req_tlast;
      end
      if (upd_go) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Controls shared by all cells.
   assign cell_ctl.update = upd_go;
   assign cell_ctl.reload = last_ff;

   // Row of list cells; a cell shifts when the moved entry lies at or
   // behind it.
   for (genvar g = 0; g < SYMBOL_COUNT; g++) begin : g_cell
      assign cell_shift[g] = |hit_ff[SYMBOL_COUNT-1:g];
      if (g == 0) begin : g_front
         assign cell_prev[g] = val_or;
      end else begin : g_rest
         assign cell_prev[g] = cell_value[g-1];
      end

      mtfc_cell #(
         .INDEX (g)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (cell_ctl),
         .shift      (cell_shift[g]),
         .prev_value (cell_prev[g]),
         .probe      (req_tdata),
         .match      (cell_match[g]),
         .value      (cell_value[g])
      );
   end

endmodule

`default_nettype wire

[design/mtfc_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Port-level checks of the coder's handshake timing.
module mtfc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tvalid,
   input wire logic       req_tready,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata
);

   // The output register is empty right after reset.
   `ASSERT_CLK(a_rsp_empty_after_reset, clock, 1'b0, reset |=> !rsp_tvalid)

   // Only one word is worked on at a time.
   `ASSERT_CLK(a_one_word_in_flight, clock, reset,
      (req_tvalid && req_tready) |=> !req_tready)

   // A new result follows its taken word through the hit vector and then the output register.
   `ASSERT_CLK(a_rsp_from_accept, clock, reset,
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))

   // A stalled result holds still.
   `ASSERT_NEVER(a_rsp_stall_hold, clock, reset,
      $past(rsp_tvalid && !rsp_tready) && !$past(reset)
      && (!rsp_tvalid || !$stable(rsp_tdata)))

endmodule

bind move_to_front_coder_unit mtfc_checker u_mtfc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

[tb/move_to_front_coder_unit_test.sv]
`timescale 1ns / 1ps

module move_to_front_coder_unit_test;
   import mtfc_pkg::*;

   localparam int SYMBOL_COUNT = 256;
   localparam int CYCLE_LIMIT = 200000;
   localparam int LONG_HOLD = 300;
   localparam int MAX_IDLE = 17;

   typedef struct {
      logic [7:0] symbol;
      logic       block_end;
   } mtf_word_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_write_enable = 1'b0;
   logic       csr_write_data = 1'b0;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;    // [7:0] symbol_in
   logic       req_tlast = 1'b0;     // block_end
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;            // [7:0] symbol_out

   // Words waiting to be sent and codes waiting to come back.
   mtf_word_type pending_words[$];
   logic [7:0]   expected_codes[$];

   // Our own copy of the recency list and of the direction register.
   logic [7:0] order_list[SYMBOL_COUNT];
   dir_type    coder_dir;

   int           fail_count = 0;
   int           cycle_count = 0;
   int           send_wait = 0;
   int           recv_wait = 0;
   int           hold_left = 0;
   int           hold_requests = 0;
   int           holds_served = 0;
   bit           send_idle_on = 1'b1;
   bit           recv_idle_on = 1'b1;
   mtf_word_type next_word;
   logic [7:0]   want_code;

   move_to_front_coder_unit #(
      .SYMBOL_COUNT(SYMBOL_COUNT)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always #4 clock = ~clock;

   // The run is cut off if it hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic void load_identity_order();
      for (int k = 0; k < SYMBOL_COUNT; k++)
         order_list[k] = k[7:0];
   endfunction

   // Returns the code for one word and moves the touched entry to the front.
   function automatic logic [7:0] mtf_predict(logic [7:0] sym, logic block_end);
      int         pos;
      logic [7:0] held;
      logic [7:0] code;
      pos = -1;
      code = 8'h00;
      if (coder_dir == DIR_ENCODE) begin
         for (int k = 0; k < SYMBOL_COUNT; k++)
            if (pos < 0 && order_list[k] == sym)
               pos = k;
         // A byte that no entry holds leaves the list alone and codes as zero.
         if (pos >= 0)
            code = pos[7:0];
      end else begin
         // Positions past the back of the list saturate to the last entry.
         pos = (sym >= SYMBOL_COUNT) ? SYMBOL_COUNT - 1 : int'(sym);
         code = order_list[pos];
      end
      if (pos >= 0) begin
         held = order_list[pos];
         for (int k = pos; k > 0; k--)
            order_list[k] = order_list[k - 1];
         order_list[0] = held;
      end
      // The end of a block restores the identity order after the code is formed.
      if (block_end)
         load_identity_order();
      return code;
   endfunction

   task automatic note_failure(string what, logic [7:0] want, logic [7:0] got);
      fail_count++;
      if (fail_count <= 10)
         $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
   endtask

   // Sender: one word per handshake, with a random gap after each word when idling is on.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_wait = 0;
      end else if (!req_tvalid || req_tready) begin
         if (send_wait > 0) begin
            send_wait--;
            req_tvalid <= 1'b0;
         end else if (pending_words.size() > 0) begin
            next_word = pending_words.pop_front();
            req_tdata <= next_word.symbol;
            req_tlast <= next_word.block_end;
            req_tvalid <= 1'b1;
            send_wait = send_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: a random stall after each taken word when idling is on, and long holds on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_wait = 0;
         hold_left = 0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= (hold_left == 0) && (recv_wait == 0);
      end else if (holds_served != hold_requests) begin
         holds_served++;
         hold_left = LONG_HOLD;
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            recv_wait = recv_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
         else if (recv_wait > 0)
            recv_wait--;
         rsp_tready <= (recv_wait == 0);
      end
   end

   // Monitor: track register writes, predict each accepted word, check each result.
   always @(posedge clock) begin
      if (reset) begin
         load_identity_order();
         coder_dir = DIR_ENCODE;
         expected_codes.delete();
      end else begin
         if (csr_write_enable)
            coder_dir = dir_type'(csr_write_data);
         if (req_tvalid && req_tready)
            expected_codes.push_back(mtf_predict(req_tdata, req_tlast));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_codes.size() == 0) begin
               note_failure("unexpected result word", 8'h00, rsp_tdata);
            end else begin
               want_code = expected_codes.pop_front();
               if (rsp_tdata !== want_code)
                  note_failure("symbol_out mismatch", want_code, rsp_tdata);
            end
         end
      end
   end

   task automatic queue_word(logic [7:0] sym, logic block_end);
      mtf_word_type w;
      w.symbol = sym;
      w.block_end = block_end;
      pending_words.push_back(w);
   endtask

   // Blocks of random length with skewed content, so that short codes and
   // repeats are common; a few blocks lose their end mark and a few get a
   // stray one in the middle.
   task automatic queue_random(int count);
      int         left;
      int         run;
      logic [7:0] sym;
      logic [7:0] prev;
      left = count;
      prev = 8'h00;
      while (left > 0) begin
         run = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 60);
         if (run > left)
            run = left;
         for (int k = 0; k < run; k++) begin
            case ($urandom_range(0, 4))
               0: sym = 8'($urandom_range(0, 255));
               1: sym = 8'($urandom_range(0, 7));
               2: sym = prev;
               3: sym = 8'($urandom_range(248, 255));
               default: sym = 8'($urandom_range(0, 31));
            endcase
            prev = sym;
            if (k == run - 1)
               queue_word(sym, $urandom_range(0, 7) != 0);
            else
               queue_word(sym, $urandom_range(0, 49) == 0);
         end
         left -= run;
      end
   endtask

   task automatic write_direction(dir_type dir);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= dir;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   // Blocks until every word has gone out and every result has come back.
   task automatic wait_idle();
      do
         @(negedge clock);
      while (pending_words.size() != 0 || req_tvalid || expected_codes.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed encoding: both ends of the byte range, repeats, and block ends,
      // including three marked words in a row.
      write_direction(DIR_ENCODE);
      queue_word(8'h00, 1'b0);
      queue_word(8'hFF, 1'b0);
      queue_word(8'hFF, 1'b0);
      queue_word(8'h00, 1'b0);
      queue_word(8'hAA, 1'b0);
      queue_word(8'h55, 1'b0);
      queue_word(8'h80, 1'b0);
      queue_word(8'h7F, 1'b0);
      queue_word(8'h01, 1'b1);
      queue_word(8'hFF, 1'b1);
      queue_word(8'hFE, 1'b1);
      wait_idle();

      // Directed decoding: front and back positions and block ends.
      write_direction(DIR_DECODE);
      queue_word(8'hFF, 1'b0);
      queue_word(8'h00, 1'b0);
      queue_word(8'hFF, 1'b0);
      queue_word(8'h01, 1'b0);
      queue_word(8'h80, 1'b0);
      queue_word(8'h55, 1'b0);
      queue_word(8'hAA, 1'b1);
      queue_word(8'hFF, 1'b1);
      queue_word(8'h00, 1'b0);
      wait_idle();

      // Random encoding with gaps on both sides.
      write_direction(DIR_ENCODE);
      queue_random(140);
      wait_idle();

      // Random decoding while the receiver holds off, so the input backs up.
      write_direction(DIR_DECODE);
      queue_random(140);
      hold_requests++;
      wait_idle();

      // Back to back, no idling on either side.
      send_idle_on = 1'b0;
      recv_idle_on = 1'b0;
      write_direction(DIR_ENCODE);
      queue_random(110);
      wait_idle();

      send_idle_on = 1'b1;
      recv_idle_on = 1'b1;
      write_direction(DIR_DECODE);
      queue_random(110);
      wait_idle();

      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
